// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/imuf_pkg.sv =====
// Types and constants of the serial IMU frame parser.
`timescale 1ns / 1ps

package imuf_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_LOW  = 8'h50;
  localparam logic [7:0] TYPE_HIGH = 8'h5F;
  localparam logic [6:0] TYPE_ACCEL = 7'h51;
  localparam logic [6:0] TYPE_GYRO  = 7'h52;
  localparam logic [6:0] TYPE_ANGLE = 7'h53;

  // Frame positions: 0 hunts for header, 10 is the checksum byte
  localparam logic [3:0] POS_HUNT  = 4'd0;
  localparam logic [3:0] POS_TYPE  = 4'd1;
  localparam logic [3:0] POS_CSUM  = 4'd10;
  localparam logic [3:0] FRAME_LEN = 4'd11;
  localparam int unsigned NUM_HELD = 10;

  // Decoded frame for one byte (fields zero when no frame completes)
  typedef struct packed {
    logic        done;
    logic        ok;
    logic [6:0]  ftype;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [15:0] value_c;
    logic [15:0] value_d;
  } frame_info_t;

  // Statistics counters
  typedef struct packed {
    logic [31:0] good;
    logic [31:0] bad;
    logic [31:0] accel;
    logic [31:0] gyro;
    logic [31:0] angle;
  } frame_counts_t;

endpackage

// ===== rtl/imu_serial_frame_parser.sv =====
// Top level of the serial IMU frame parser: stream ports and result register.
// A result appears on the master side in the cycle after its byte is taken.
// Throughput: one byte per cycle; a new byte is taken while a result waits, as
// long as the result register is empty or being drained in that cycle.
// Reset (rst, synchronous): parser hunts for a header, all counts are zero,
// and no result is pending.
`timescale 1ns / 1ps

module imu_serial_frame_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic         m_tlast,   // frame_done
  // checksum_ok[0], frame_type[7:1], value_a[23:8], value_b[39:24],
  // value_c[55:40], value_d[71:56], good_frames[103:72], bad_sums[135:104],
  // accel_cnt[167:136], gyro_cnt[199:168], angle_cnt[231:200]
  output logic [231:0] m_tdata
);

  logic                    accept;
  imuf_pkg::frame_info_t   info;
  imuf_pkg::frame_counts_t counts_next;

  // Take a byte when the result register is free or drains this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  imuf_frame_asm u_asm (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_tdata),
    .info    (info)
  );

  imuf_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .info        (info),
    .counts_next (counts_next)
  );

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tlast <= info.done;
      m_tdata <= {counts_next.angle, counts_next.gyro, counts_next.accel,
                  counts_next.bad, counts_next.good,
                  info.value_d, info.value_c, info.value_b, info.value_a,
                  info.ftype, info.ok};
    end
  end

endmodule

// ===== rtl/imuf_frame_asm.sv =====
// Frame assembler: header hunt, type check, byte store, running checksum.
`timescale 1ns / 1ps

module imuf_frame_asm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  output imuf_pkg::frame_info_t info
);

  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [7:0] sum;
  logic [7:0] sum_next;
  logic       wr;
  logic [3:0] waddr;
  logic [7:0] frame_bytes [imuf_pkg::NUM_HELD];

  // Next position, running sum and decode of a completed frame
  always_comb begin
    pos_next = imuf_pkg::POS_HUNT;
    sum_next = sum;
    wr       = 1'b0;
    waddr    = pos;
    info     = '0;
    if (pos == imuf_pkg::POS_HUNT || pos >= imuf_pkg::FRAME_LEN) begin
      if (rx_byte == imuf_pkg::HDR_BYTE) begin
        wr       = 1'b1;
        waddr    = imuf_pkg::POS_HUNT;
        pos_next = imuf_pkg::POS_TYPE;
        sum_next = rx_byte;
      end
    end else if (pos == imuf_pkg::POS_TYPE) begin
      if (rx_byte >= imuf_pkg::TYPE_LOW && rx_byte <= imuf_pkg::TYPE_HIGH) begin
        wr       = 1'b1;
        pos_next = pos + 4'd1;
        sum_next = sum + rx_byte;
      end
    end else if (pos < imuf_pkg::POS_CSUM) begin
      wr       = 1'b1;
      pos_next = pos + 4'd1;
      sum_next = sum + rx_byte;
    end else begin
      // checksum byte closes the frame
      info.done    = 1'b1;
      info.ok      = (sum == rx_byte);
      info.ftype   = frame_bytes[1][6:0];
      info.value_a = {frame_bytes[3], frame_bytes[2]};
      info.value_b = {frame_bytes[5], frame_bytes[4]};
      info.value_c = {frame_bytes[7], frame_bytes[6]};
      info.value_d = {frame_bytes[9], frame_bytes[8]};
    end
  end

  // Position register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= imuf_pkg::POS_HUNT;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // Frame byte store and running sum
  always_ff @(posedge clk) begin
    if (accept) begin
      sum <= sum_next;
      if (wr) begin
        frame_bytes[waddr] <= rx_byte;
      end
    end
  end

endmodule

// ===== rtl/imuf_stats.sv =====
// Wrapping frame statistics counters.
`timescale 1ns / 1ps

module imuf_stats (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  imuf_pkg::frame_info_t  info,
  output imuf_pkg::frame_counts_t counts_next
);

  imuf_pkg::frame_counts_t counts;

  // Counts after this transaction
  always_comb begin
    counts_next = counts;
    if (info.done) begin
      if (info.ok) begin
        counts_next.good = counts.good + 32'd1;
        case (info.ftype)
          imuf_pkg::TYPE_ACCEL: counts_next.accel = counts.accel + 32'd1;
          imuf_pkg::TYPE_GYRO:  counts_next.gyro  = counts.gyro + 32'd1;
          imuf_pkg::TYPE_ANGLE: counts_next.angle = counts.angle + 32'd1;
          default: ;
        endcase
      end else begin
        counts_next.bad = counts.bad + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (accept) begin
      counts <= counts_next;
    end
  end

endmodule

// ===== rtl/imuf_checker.sv =====
// Port-level checker for the serial IMU frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imuf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [7:0]   s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic         m_tlast,
  input logic [231:0] m_tdata
);

  // Stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // Empty result register always takes a byte
  `ASSERT_SAME(a_ready, clk, rst, !m_tvalid, s_tready)
  // Checksum status only on a completed frame
  `ASSERT_SAME(a_ok_done, clk, rst, m_tvalid && m_tdata[0], m_tlast)
  // Frame fields are zero when no frame completed
  `ASSERT_SAME(a_zero, clk, rst, m_tvalid && !m_tlast, m_tdata[71:0] == 72'd0)
  // Completed frame carries a type in 0x50..0x5F (top three of the seven bits)
  `ASSERT_SAME(a_type, clk, rst, m_tvalid && m_tlast, m_tdata[7:5] == 3'b101)

endmodule

bind imu_serial_frame_parser imuf_checker u_chk (.*);

// ===== dv/tb_imu_serial_frame_parser.sv =====
// Self-checking testbench for the serial IMU frame parser stream block.
`timescale 1ns / 1ps

module tb_imu_serial_frame_parser;

  // Expected output for one accepted byte
  typedef struct packed {
    imuf_pkg::frame_info_t   info;
    imuf_pkg::frame_counts_t counts;
  } parse_result_t;

  // Frame parser predictor plus queue of expected results
  class frame_scoreboard;
    logic [3:0]              pos;
    logic [7:0]              held [imuf_pkg::NUM_HELD];
    imuf_pkg::frame_counts_t tally;
    parse_result_t           expected_q [$];
    int                      mismatches;

    function new();
      pos        = imuf_pkg::POS_HUNT;
      tally      = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the parser state by one received byte and queue its result
    function void note_byte(logic [7:0] b);
      parse_result_t r;
      logic [7:0]    sum;
      int            i;
      r      = '0;
      if (pos == imuf_pkg::POS_HUNT || pos >= imuf_pkg::FRAME_LEN) begin
        if (b == imuf_pkg::HDR_BYTE) begin
          held[0] = b;
          pos     = imuf_pkg::POS_TYPE;
        end else begin
          pos = imuf_pkg::POS_HUNT;
        end
      end else if (pos == imuf_pkg::POS_TYPE) begin
        if (b >= imuf_pkg::TYPE_LOW && b <= imuf_pkg::TYPE_HIGH) begin
          held[1] = b;
          pos     = imuf_pkg::POS_TYPE + 4'd1;
        end else begin
          pos = imuf_pkg::POS_HUNT;
        end
      end else if (pos != imuf_pkg::POS_CSUM) begin
        held[pos] = b;
        pos       = pos + 4'd1;
      end else begin
        // checksum byte: additive sum of the ten held bytes
        sum = 8'd0;
        for (i = 0; i < imuf_pkg::NUM_HELD; i++) sum = sum + held[i];
        r.info.done    = 1'b1;
        r.info.ok      = (sum == b);
        r.info.ftype   = held[1][6:0];
        r.info.value_a = {held[3], held[2]};
        r.info.value_b = {held[5], held[4]};
        r.info.value_c = {held[7], held[6]};
        r.info.value_d = {held[9], held[8]};
        if (r.info.ok) begin
          case (held[1][6:0])
            imuf_pkg::TYPE_ACCEL: tally.accel = tally.accel + 32'd1;
            imuf_pkg::TYPE_GYRO:  tally.gyro  = tally.gyro + 32'd1;
            imuf_pkg::TYPE_ANGLE: tally.angle = tally.angle + 32'd1;
            default: ;
          endcase
          tally.good = tally.good + 32'd1;
        end else begin
          tally.bad = tally.bad + 32'd1;
        end
        pos = imuf_pkg::POS_HUNT;
      end
      r.counts = tally;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    // Compare one output transaction with the oldest expectation
    function void check_result(logic last, logic [231:0] data);
      parse_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transaction: tlast %0b tdata %0h", last, data);
        return;
      end
      want = expected_q.pop_front();
      check_field("frame_done",   want.info.done,    last);
      check_field("checksum_ok",  want.info.ok,      data[0]);
      check_field("frame_type",   want.info.ftype,   data[7:1]);
      check_field("value_a",      want.info.value_a, data[23:8]);
      check_field("value_b",      want.info.value_b, data[39:24]);
      check_field("value_c",      want.info.value_c, data[55:40]);
      check_field("value_d",      want.info.value_d, data[71:56]);
      check_field("good_frames",  want.counts.good,  data[103:72]);
      check_field("bad_sums",     want.counts.bad,   data[135:104]);
      check_field("accel_cnt",    want.counts.accel, data[167:136]);
      check_field("gyro_cnt",     want.counts.gyro,  data[199:168]);
      check_field("angle_cnt",    want.counts.angle, data[231:200]);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic         m_tlast;
  logic [231:0] m_tdata;

  frame_scoreboard sb;
  bit              quiet = 1'b0;  // no idling on either side while set
  int              bytes_sent = 0;

  imu_serial_frame_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Receiver: random backpressure, check each output transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tlast, m_tdata);
    m_tready <= quiet || ($urandom_range(99) >= 12);
  end

  // Offer one byte, with an optional idle cycle first, and wait for acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (!quiet && $urandom_range(99) < 12) ? 1 : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Hold off the sender until every expected result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Full 11-byte frame, checksum right or deliberately wrong
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] va,
                            input logic [15:0] vb, input logic [15:0] vc,
                            input logic [15:0] vd, input bit good_sum);
    logic [7:0] fb [11];
    logic [7:0] sum;
    int         i;
    fb[0] = imuf_pkg::HDR_BYTE;
    fb[1] = ftype;
    fb[2] = va[7:0];
    fb[3] = va[15:8];
    fb[4] = vb[7:0];
    fb[5] = vb[15:8];
    fb[6] = vc[7:0];
    fb[7] = vc[15:8];
    fb[8] = vd[7:0];
    fb[9] = vd[15:8];
    sum   = 8'd0;
    for (i = 0; i < 10; i++) sum = sum + fb[i];
    fb[10] = good_sum ? sum : sum + 8'($urandom_range(1, 255));
    for (i = 0; i < 11; i++) send_byte(fb[i]);
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(7))
      0, 1:    return {1'b0, imuf_pkg::TYPE_ACCEL};
      2, 3:    return {1'b0, imuf_pkg::TYPE_GYRO};
      4, 5:    return {1'b0, imuf_pkg::TYPE_ANGLE};
      default: return imuf_pkg::TYPE_LOW + 8'($urandom_range(15));
    endcase
  endfunction

  // Stimulus
  initial begin
    int choice;
    int n;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: noise extremes, rejected type bytes just outside the range
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(imuf_pkg::HDR_BYTE);
    send_byte(imuf_pkg::TYPE_LOW - 8'd1);
    send_byte(imuf_pkg::HDR_BYTE);
    send_byte(imuf_pkg::TYPE_HIGH + 8'd1);
    // Header value in the type slot, extreme words, good checksum
    send_frame(imuf_pkg::HDR_BYTE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b1);
    // Top of the type range with a bad checksum
    send_frame(imuf_pkg::TYPE_HIGH, 16'h0001, 16'hFFFE, 16'h8001, 16'h7FFE, 1'b0);
    drain_results();

    // Random: mostly well-formed frames, some broken ones and noise
    while (bytes_sent < 450) begin
      quiet  = (bytes_sent >= 200 && bytes_sent < 320);
      choice = $urandom_range(99);
      if (choice < 70) begin
        send_frame(pick_type(), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), $urandom_range(9) != 0);
      end else if (choice < 80) begin
        // frame cut short; next bytes land inside it
        send_byte(imuf_pkg::HDR_BYTE);
        send_byte(pick_type());
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom_range(255)));
      end else if (choice < 90) begin
        send_byte(imuf_pkg::HDR_BYTE);
        send_byte(8'($urandom_range(255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(255)));
      end
      if (bytes_sent >= 330 && bytes_sent < 345) drain_results();
    end
    s_tvalid <= 1'b0;
    quiet = 1'b0;

    // Wait for the last results, then keep watching for stray outputs
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== imu_serial_frame_parser.f =====
+incdir+rtl
rtl/imuf_pkg.sv
rtl/imuf_frame_asm.sv
rtl/imuf_stats.sv
rtl/imu_serial_frame_parser.sv
rtl/imuf_checker.sv
dv/tb_imu_serial_frame_parser.sv
